// ===== hdl/bad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_pkg: shared types, constants and helpers for the ANF degree block
// Sizes of the truth table store, lane count words and the bit masks used by
// the in-word butterfly and the per-lane weight counting.
// ----------------------------------------------------------------------------
package bad_pkg;

  localparam int MAX_INPUTS   = 8;
  localparam int TABLE_WORDS  = ((1 << MAX_INPUTS) > 32) ? ((1 << MAX_INPUTS) >> 5) : 1;
  localparam int LANE_CLASSES = 6;   // bit weights 0..5 inside one 32-bit word
  localparam int LCNT_W       = 4;   // at most 10 bits of one weight per word
  localparam int CNT_W        = 9;   // up to 256 monomials
  localparam int DEG_W        = 5;
  localparam int NB_W         = 4;   // width of the variable count

  typedef logic [31:0] word_t;
  typedef logic [LANE_CLASSES-1:0][LCNT_W-1:0] lane_cnt_t;
  typedef logic [CNT_W-1:0] wcnt_t;

  // population count of a 5-bit value
  function automatic logic [2:0] pop5(input logic [4:0] v);
    logic [2:0] c;
    c = '0;
    for (int i = 0; i < 5; i++) c = c + {2'b00, v[i]};
    return c;
  endfunction

  // butterfly partner mask for in-word stage b
  function automatic word_t half_mask(input logic [2:0] b);
    word_t m;
    case (b)
      3'd0:    m = 32'h5555_5555;
      3'd1:    m = 32'h3333_3333;
      3'd2:    m = 32'h0F0F_0F0F;
      3'd3:    m = 32'h00FF_00FF;
      default: m = 32'h0000_FFFF;
    endcase
    return m;
  endfunction

  // bit positions whose index has weight k
  function automatic word_t class_mask(input logic [2:0] k);
    word_t m;
    m = '0;
    for (int i = 0; i < 32; i++) m[i] = (pop5(5'(i)) == k);
    return m;
  endfunction

  // valid table bits of word 0 for small functions
  function automatic word_t low_mask(input logic [NB_W-1:0] n);
    word_t m;
    case (n)
      4'd1:    m = 32'h0000_0003;
      4'd2:    m = 32'h0000_000F;
      4'd3:    m = 32'h0000_00FF;
      4'd4:    m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // variable count forced into 1..MAX_INPUTS
  function automatic logic [NB_W-1:0] clamp_n(input logic [NB_W-1:0] raw);
    logic [NB_W-1:0] n;
    n = raw;
    if (raw == '0) n = NB_W'(1);
    else if (raw > NB_W'(MAX_INPUTS)) n = NB_W'(MAX_INPUTS);
    return n;
  endfunction

  // table words for n variables
  function automatic logic [NB_W-1:0] word_total(input logic [NB_W-1:0] n);
    logic [NB_W-1:0] w;
    w = NB_W'(1);
    if (n > NB_W'(5)) w = NB_W'(1) << (n - NB_W'(5));
    return w;
  endfunction

endpackage

// ===== hdl/bad_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_lane: in-word Moebius butterfly for one table word
// Runs the XOR butterfly over input bits 0..4 (those below n) and registers
// the transformed word.
// ----------------------------------------------------------------------------
module bad_lane
  import bad_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [NB_W-1:0] n_i,
  input  word_t           word_i,
  output word_t           word_o
);

  word_t word_r;
  word_t word_nxt;

  // five butterfly stages, stage b skipped unless b < n
  always_comb begin
    word_nxt = word_i;
    for (int b = 0; b < 5; b++) begin
      if (NB_W'(b) < n_i) begin
        word_nxt = word_nxt ^ ((word_nxt & half_mask(3'(b))) << (1 << b));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) word_r <= word_nxt;
  end

  assign word_o = word_r;

endmodule

// ===== hdl/bad_lcnt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_lcnt: per-lane monomial counter
// Counts the set ANF bits of one word, split by the weight of the bit
// position inside the word (0..5).
// ----------------------------------------------------------------------------
module bad_lcnt
  import bad_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  word_t     word_i,
  output lane_cnt_t cnt_o
);

  lane_cnt_t cnt_r;
  lane_cnt_t cnt_nxt;
  word_t     sel;

  // one popcount per weight class
  always_comb begin
    cnt_nxt = '0;
    sel     = '0;
    for (int k = 0; k < LANE_CLASSES; k++) begin
      sel = word_i & class_mask(3'(k));
      for (int i = 0; i < 32; i++) begin
        cnt_nxt[k] = cnt_nxt[k] + {{(LCNT_W-1){1'b0}}, sel[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) cnt_r <= cnt_nxt;
  end

  assign cnt_o = cnt_r;

endmodule

// ===== hdl/bad_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_merge: combines lane counts into per-weight monomial counts
// A bit of word j at in-word weight k is a monomial of weight k + wt(j);
// only lanes that hold a table word of this run take part.
// ----------------------------------------------------------------------------
module bad_merge
  import bad_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [NB_W-1:0] nwords_i,
  input  lane_cnt_t       lane_cnt_i [TABLE_WORDS],
  output wcnt_t           cnt_o [MAX_INPUTS+1]
);

  wcnt_t      cnt_r   [MAX_INPUTS+1];
  wcnt_t      cnt_nxt [MAX_INPUTS+1];
  logic [2:0] pj;

  // sum each lane's class count into the matching total weight
  always_comb begin
    pj = '0;
    for (int w = 0; w <= MAX_INPUTS; w++) begin
      cnt_nxt[w] = '0;
      for (int j = 0; j < TABLE_WORDS; j++) begin
        pj = pop5(5'(j));
        if ((NB_W'(j) < nwords_i) && (w >= int'(pj)) &&
            (w - int'(pj) < LANE_CLASSES)) begin
          cnt_nxt[w] = cnt_nxt[w] +
                       CNT_W'(lane_cnt_i[j][3'(w - int'(pj))]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w <= MAX_INPUTS; w++) cnt_r[w] <= cnt_nxt[w];
    end
  end

  assign cnt_o = cnt_r;

endmodule

// ===== hdl/boolean_anf_degree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boolean_anf_degree: algebraic normal form and degree of a Boolean function
// Loads a truth table word by word, applies the binary Moebius transform in
// eight parallel lanes and reports ANF words, weight counts and the degree.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: register input_bits (n, clamped to 1..8) at byte address 0
//   of the APB port; writing it restarts loading. Reset value is 8.
//   Input: one 32-bit truth-table word whenever start is high and busy is low.
//   W = max(1, 2^n/32) words complete a table; loading takes one word a cycle.
//   After the last word, busy stays high through processing (in-word
//   butterfly, cross-word butterfly, lane counts, merge, degree) and then
//   through emission: the W ANF words, then the counts for weights 0..n.
//   Each result word is shown for one cycle with out_strobe; out_last_result
//   marks the count for weight n. The receiver cannot stall the block.
//   For a full 8-variable table, as for any other, no new word is taken until
//   all results have left one by one through the single output register.
//   Reset returns the block to loading with no words held; the store itself
//   is not cleared, each run reads only the words written in that run.
// ----------------------------------------------------------------------------
module boolean_anf_degree
  import bad_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // APB configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // input channel
  input  logic                    start,
  output logic                    busy,
  input  logic [31:0]             in_truth_word,
  // result channel
  output logic                    out_strobe,
  output logic                    out_result_kind,
  output logic [2:0]              out_word_index,
  output logic [31:0]             out_anf_word,
  output logic [3:0]              out_monomial_weight,
  output logic [CNT_W-1:0]        out_monomial_count,
  output logic signed [DEG_W-1:0] out_algebraic_degree,
  output logic                    out_last_result
);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_XFORM = 7'b0000010,
    S_CROSS = 7'b0000100,
    S_COUNT = 7'b0001000,
    S_MERGE = 7'b0010000,
    S_DEG   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [NB_W-1:0]         nbits_r;
  logic [2:0]              wl_r;
  logic [4:0]              ecnt_r;
  word_t                   store_r  [TABLE_WORDS];
  word_t                   lane_in  [TABLE_WORDS];
  word_t                   lane_out [TABLE_WORDS];
  word_t                   cross_r  [TABLE_WORDS];
  word_t                   cross_nxt[TABLE_WORDS];
  lane_cnt_t               lane_cnt [TABLE_WORDS];
  wcnt_t                   wcnt     [MAX_INPUTS+1];
  logic signed [DEG_W-1:0] deg_r, deg_nxt;
  logic [NB_W-1:0]         n_eff;
  logic [NB_W-1:0]         nwords;
  logic [2:0]              nwords_m1;
  logic                    cfg_wr;
  logic                    in_acc;
  logic [4:0]              n_words5;
  logic [4:0]              weight5;
  logic                    emit_word;
  logic                    emit_last;

  logic                    out_strobe_r;
  logic                    out_kind_r;
  logic [2:0]              out_idx_r;
  word_t                   out_word_r;
  logic [3:0]              out_wt_r;
  wcnt_t                   out_cnt_r;
  logic                    out_last_r;

  assign n_eff     = clamp_n(nbits_r);
  assign nwords    = word_total(n_eff);
  assign nwords_m1 = 3'(nwords - NB_W'(1));
  assign n_words5  = 5'(nwords);
  assign cfg_wr    = psel && penable && pwrite && pready && !paddr[2];
  assign busy      = (state_r != S_LOAD);
  assign in_acc    = start && !busy;

  // APB register file
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {28'd0, nbits_r};

  // emission select
  assign weight5   = ecnt_r - n_words5;
  assign emit_word = (ecnt_r < n_words5);
  assign emit_last = !emit_word && (weight5[3:0] == n_eff);

  // control state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (in_acc && (wl_r == nwords_m1)) state_nxt = S_XFORM;
      S_XFORM: state_nxt = S_CROSS;
      S_CROSS: state_nxt = S_COUNT;
      S_COUNT: state_nxt = S_MERGE;
      S_MERGE: state_nxt = S_DEG;
      S_DEG:   state_nxt = S_EMIT;
      S_EMIT:  if (emit_last) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      nbits_r      <= NB_W'(MAX_INPUTS);
      wl_r         <= '0;
      ecnt_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_EMIT);
      if (cfg_wr) nbits_r <= pwdata[NB_W-1:0];
      // word counter: restarts on a register write or a complete table
      if (cfg_wr) wl_r <= '0;
      else if (in_acc) wl_r <= (wl_r == nwords_m1) ? 3'd0 : wl_r + 3'd1;
      if (state_r == S_EMIT) ecnt_r <= emit_last ? 5'd0 : ecnt_r + 5'd1;
    end
  end

  // truth table store
  always_ff @(posedge clk) begin
    if (in_acc) store_r[wl_r] <= in_truth_word;
  end

  // lanes: in-word butterfly and per-lane weight counts
  for (genvar j = 0; j < TABLE_WORDS; j++) begin : g_lane
    assign lane_in[j] = store_r[j] & low_mask(n_eff);

    bad_lane u_lane (
      .clk    (clk),
      .en     (state_r == S_XFORM),
      .n_i    (n_eff),
      .word_i (lane_in[j]),
      .word_o (lane_out[j])
    );

    bad_lcnt u_lcnt (
      .clk    (clk),
      .en     (state_r == S_COUNT),
      .word_i (cross_r[j]),
      .cnt_o  (lane_cnt[j])
    );
  end

  // cross-word butterfly for input bits 5 and up
  always_comb begin
    for (int j = 0; j < TABLE_WORDS; j++) cross_nxt[j] = lane_out[j];
    for (int k = 0; k < MAX_INPUTS - 5; k++) begin
      for (int j = 0; j < TABLE_WORDS; j++) begin
        if ((n_eff > NB_W'(5 + k)) && (((j >> k) & 1) == 1)) begin
          cross_nxt[j] = cross_nxt[j] ^ cross_nxt[j ^ (1 << k)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CROSS) begin
      for (int j = 0; j < TABLE_WORDS; j++) cross_r[j] <= cross_nxt[j];
    end
  end

  bad_merge u_merge (
    .clk        (clk),
    .en         (state_r == S_MERGE),
    .nwords_i   (nwords),
    .lane_cnt_i (lane_cnt),
    .cnt_o      (wcnt)
  );

  // degree: highest weight with a nonzero count
  always_comb begin
    deg_nxt = '1;
    for (int w = 0; w <= MAX_INPUTS; w++) begin
      if (wcnt[w] != '0) deg_nxt = DEG_W'(w);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DEG) deg_r <= deg_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_EMIT) begin
      out_kind_r <= !emit_word;
      out_last_r <= emit_last;
      if (emit_word) begin
        out_idx_r  <= ecnt_r[2:0];
        out_word_r <= cross_r[ecnt_r[2:0]];
        out_wt_r   <= '0;
        out_cnt_r  <= '0;
      end else begin
        out_idx_r  <= '0;
        out_word_r <= '0;
        out_wt_r   <= weight5[3:0];
        out_cnt_r  <= wcnt[weight5[3:0]];
      end
    end
  end

  assign out_strobe           = out_strobe_r;
  assign out_result_kind      = out_kind_r;
  assign out_word_index       = out_idx_r;
  assign out_anf_word         = out_word_r;
  assign out_monomial_weight  = out_wt_r;
  assign out_monomial_count   = out_cnt_r;
  assign out_algebraic_degree = deg_r;
  assign out_last_result      = out_last_r;

  // checks
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_result |=> !out_strobe)
    else $error("result strobe after the last result of a run");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a run in progress");

  a_full_table_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (wl_r == nwords_m1) |=> state_r == S_XFORM)
    else $error("complete table did not start the transform");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> ecnt_r <= n_words5 + 5'(n_eff))
    else $error("emit counter ran past the last result");

endmodule

// ===== bench/boolean_anf_degree_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boolean_anf_degree_tb: self-checking bench for the ANF / degree block
// Feeds truth-table words through the start/busy channel under a range of
// input_bits settings (clamped values included), predicts every ANF word and
// weight count with a bit-level Moebius transform, and compares each strobed
// result field by field. Short directed table first, then random phases.
// ----------------------------------------------------------------------------
module boolean_anf_degree_tb;
  import bad_pkg::*;

  localparam logic [2:0] REG_INPUT_BITS = 3'd0;   // byte address of input_bits
  localparam logic       KIND_ANF       = 1'b0;
  localparam logic       KIND_COUNT     = 1'b1;
  localparam int         SETTLE_CYCLES  = 40;     // covers processing and emission, with margin
  localparam int         WATCHDOG_LIMIT = 1500;
  localparam int         NUM_PHASES     = 12;
  localparam int         NUM_DIR        = 22;

  typedef struct packed {
    logic                    kind;
    logic [2:0]              word_idx;
    logic [31:0]             anf;
    logic [3:0]              weight;
    logic [CNT_W-1:0]        count;
    logic signed [DEG_W-1:0] degree;
    logic                    last;
  } anf_result_t;

  typedef struct packed {
    logic             wr;      // write input_bits before this word
    logic [3:0]       n_val;
    logic [31:0]      word;
    logic             typed;   // ANF word 0 and degree given below
    logic [31:0]      t_anf;
    logic signed [4:0] t_deg;
  } dir_row_t;

  // directed words: extremes, clamping, masking of small tables, restart
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{1'b0, 4'd0, 32'hFFFF_FFFF, 1'b0, 32'h0,         5'sd0},
    '{1'b0, 4'd0, 32'hFFFF_FFFF, 1'b0, 32'h0,         5'sd0},
    '{1'b0, 4'd0, 32'hFFFF_FFFF, 1'b0, 32'h0,         5'sd0},
    '{1'b0, 4'd0, 32'hFFFF_FFFF, 1'b0, 32'h0,         5'sd0},
    '{1'b0, 4'd0, 32'hFFFF_FFFF, 1'b0, 32'h0,         5'sd0},
    '{1'b0, 4'd0, 32'hFFFF_FFFF, 1'b0, 32'h0,         5'sd0},
    '{1'b0, 4'd0, 32'hFFFF_FFFF, 1'b0, 32'h0,         5'sd0},
    '{1'b0, 4'd0, 32'hFFFF_FFFF, 1'b1, 32'h1,         5'sd0},
    '{1'b1, 4'd1, 32'hFFFF_FFFF, 1'b1, 32'h1,         5'sd0},
    '{1'b0, 4'd0, 32'h0000_0002, 1'b1, 32'h2,         5'sd1},
    '{1'b1, 4'd0, 32'h0000_0001, 1'b1, 32'h3,         5'sd1},
    '{1'b1, 4'd2, 32'hABCD_EF06, 1'b1, 32'h6,         5'sd1},
    '{1'b1, 4'd3, 32'hFFFF_FF96, 1'b1, 32'h16,        5'sd1},
    '{1'b1, 4'd4, 32'hFFFF_0000, 1'b1, 32'h0,        -5'sd1},
    '{1'b0, 4'd0, 32'h0000_8000, 1'b1, 32'h8000,      5'sd4},
    '{1'b1, 4'd5, 32'h8000_0000, 1'b1, 32'h8000_0000, 5'sd5},
    '{1'b0, 4'd0, 32'h5555_5555, 1'b1, 32'h3,         5'sd1},
    '{1'b1, 4'd6, 32'h1234_5678, 1'b0, 32'h0,         5'sd0},
    '{1'b1, 4'd7, 32'hDEAD_BEEF, 1'b0, 32'h0,         5'sd0},
    '{1'b0, 4'd0, 32'h0000_0000, 1'b0, 32'h0,         5'sd0},
    '{1'b0, 4'd0, 32'hA5A5_A5A5, 1'b0, 32'h0,         5'sd0},
    '{1'b0, 4'd0, 32'h8000_0000, 1'b0, 32'h0,         5'sd0}
  };

  // variable counts per random phase, out-of-range values included
  localparam logic [3:0] PHASE_N [NUM_PHASES] = '{
    4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd6, 4'd2, 4'd9, 4'd4, 4'd7, 4'd5, 4'd8
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [2:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    start = 1'b0;
  logic                    busy;
  logic [31:0]             in_truth_word = '0;
  logic                    out_strobe;
  logic                    out_result_kind;
  logic [2:0]              out_word_index;
  logic [31:0]             out_anf_word;
  logic [3:0]              out_monomial_weight;
  logic [CNT_W-1:0]        out_monomial_count;
  logic signed [DEG_W-1:0] out_algebraic_degree;
  logic                    out_last_result;

  // predictor state and bookkeeping
  anf_result_t anf_due [$];
  logic [3:0]  model_n_raw = 4'd8;
  int          model_loaded = 0;
  logic [31:0] model_table [8];
  logic        idle_on = 1'b0;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          words_sent = 0;
  int          tables_done = 0;
  int          cfg_writes = 0;
  int          quiet_cycles = 0;

  boolean_anf_degree u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .start                (start),
    .busy                 (busy),
    .in_truth_word        (in_truth_word),
    .out_strobe           (out_strobe),
    .out_result_kind      (out_result_kind),
    .out_word_index       (out_word_index),
    .out_anf_word         (out_anf_word),
    .out_monomial_weight  (out_monomial_weight),
    .out_monomial_count   (out_monomial_count),
    .out_algebraic_degree (out_algebraic_degree),
    .out_last_result      (out_last_result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  // take one truth word; on a complete table push its ANF words and counts
  task automatic absorb_word(input logic [31:0] w, output int added);
    int n, nw, m, b, j, wt;
    logic [255:0] tt;
    int cnt [9];
    logic signed [4:0] deg;
    anf_result_t r;
    added = 0;
    n = (model_n_raw == 4'd0) ? 1 : (model_n_raw > 4'd8) ? 8 : int'(model_n_raw);
    nw = (n > 5) ? (1 << (n - 5)) : 1;
    if (model_loaded < 8) model_table[model_loaded] = w;
    model_loaded = (model_loaded + 1) % 16;
    if (model_loaded < nw) return;
    model_loaded = 0;
    // bits beyond 2^n stay zero, which also clears the top of small tables
    tt = '0;
    for (m = 0; m < (1 << n); m++) tt[m] = model_table[m >> 5][m & 31];
    // XOR butterfly, one stage per variable
    for (b = 0; b < n; b++) begin
      for (m = 0; m < (1 << n); m++) begin
        if ((m >> b) & 1) tt[m] = tt[m] ^ tt[m ^ (1 << b)];
      end
    end
    for (j = 0; j < 9; j++) cnt[j] = 0;
    deg = -5'sd1;
    for (m = 0; m < (1 << n); m++) begin
      if (tt[m]) begin
        wt = $countones(m);
        cnt[wt]++;
        if (wt > deg) deg = 5'(wt);
      end
    end
    for (j = 0; j < nw; j++) begin
      r = '{kind: KIND_ANF, word_idx: 3'(j), anf: tt[j*32 +: 32], weight: '0,
            count: '0, degree: deg, last: 1'b0};
      anf_due.push_back(r);
      added++;
    end
    for (j = 0; j <= n; j++) begin
      r = '{kind: KIND_COUNT, word_idx: '0, anf: '0, weight: 4'(j),
            count: CNT_W'(cnt[j]), degree: deg, last: (j == n)};
      anf_due.push_back(r);
      added++;
    end
    tables_done++;
  endtask

  // present one word and hold it until the block takes it
  task automatic push_word(input logic [31:0] w, output int added);
    start <= 1'b1;
    in_truth_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    absorb_word(w, added);
    words_sent++;
  endtask

  // occasional random sender gap while idle_on is set, junk on the data bus meanwhile
  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      in_truth_word <= $urandom();
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // hold off until every pending result is back and the block has settled
  task automatic drain();
    start <= 1'b0;
    while (anf_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of input_bits: setup then access phase
  task automatic write_input_bits(input logic [3:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_INPUT_BITS;
    pwdata  <= {28'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_n_raw = v;
    model_loaded = 0;
    cfg_writes++;
  endtask

  function automatic logic [31:0] random_word();
    logic [4:0] s;
    s = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << s;
      3:       return ~(32'h1 << s);
      4:       return $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  // compare each strobed result with the oldest pending one
  always @(posedge clk) begin : result_check
    anf_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (anf_due.size() == 0) begin
        note_mismatch("result with none pending", out_anf_word, 32'h0);
      end else begin
        want = anf_due.pop_front();
        results_seen++;
        if (out_result_kind !== want.kind)
          note_mismatch("result_kind", out_result_kind, want.kind);
        if (out_word_index !== want.word_idx)
          note_mismatch("word_index", out_word_index, want.word_idx);
        if (out_anf_word !== want.anf)
          note_mismatch("anf_word", out_anf_word, want.anf);
        if (out_monomial_weight !== want.weight)
          note_mismatch("monomial_weight", out_monomial_weight, want.weight);
        if (out_monomial_count !== want.count)
          note_mismatch("monomial_count", out_monomial_count, want.count);
        if (out_algebraic_degree !== want.degree)
          note_mismatch("algebraic_degree", {27'b0, out_algebraic_degree},
                        {27'b0, want.degree});
        if (out_last_result !== want.last)
          note_mismatch("last_result", out_last_result, want.last);
      end
    end
  end

  // watchdog: cycles with no word in, no result out and no register write
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int i, p, k, items, added, j, directed_words;
    anf_result_t e;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    idle_on = 1'b1;
    for (i = 0; i < NUM_DIR; i++) begin
      if (DIR_ROWS[i].wr) begin
        drain();
        write_input_bits(DIR_ROWS[i].n_val);
      end
      sender_gap();
      push_word(DIR_ROWS[i].word, added);
      // hand-worked rows override the predictor's ANF word 0 and degree
      if (DIR_ROWS[i].typed) begin
        for (j = anf_due.size() - added; j < anf_due.size(); j++) begin
          e = anf_due[j];
          e.degree = DIR_ROWS[i].t_deg;
          if (e.kind == KIND_ANF && e.word_idx == 3'd0) e.anf = DIR_ROWS[i].t_anf;
          anf_due[j] = e;
        end
      end
    end
    directed_words = words_sent;

    // random phases; a phase may stop mid-table, the next write restarts loading
    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_input_bits(PHASE_N[p]);
      idle_on = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      items = $urandom_range(12, 20);
      for (k = 0; k < items; k++) begin
        if (p == 3 && k == 5) drain();
        sender_gap();
        push_word(random_word(), added);
      end
    end

    drain();
    $display("covered %0d words (%0d directed), %0d complete tables, %0d results checked",
             words_sent, directed_words, tables_done, results_seen);
    $display("input_bits written %0d times, from 0 to 15 including clamped values",
             cfg_writes);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bad_pkg.sv
hdl/bad_lane.sv
hdl/bad_lcnt.sv
hdl/bad_merge.sv
hdl/boolean_anf_degree.sv
bench/boolean_anf_degree_tb.sv
